/* rtl/vbsp_pkg.sv */
// Package with the constants and types shared by the varint bit scanner.
package vbsp_pkg;

   // Default limit on the number of bytes in one number.
   localparam int DEFAULT_MAX_BYTES = 16;

   // Byte format constants.
   localparam logic [7:0] GROUP_VALUE_MASK = 8'h7F;
   localparam int         CONT_BIT         = 7;
   localparam int         BYTE_BITS        = 8;
   localparam int         GROUP_BITS       = 7;

   // Saturation limits of the running state.
   localparam logic [6:0] INDEX_MAX  = 7'h7F;
   localparam logic [7:0] OFFSET_MAX = 8'hFF;
   localparam logic [7:0] COUNT_MAX  = 8'hFF;

   // Value reported for the bit indexes of a zero number.
   localparam logic [7:0] NO_BIT_SET = 8'hFF;

   // Widths of the request and result words.
   localparam int REQ_DATA_WIDTH = 8;
   localparam int RSP_DATA_WIDTH = 32;

   // Result fields before they are packed into the result word.
   typedef struct packed {
      logic       too_long;
      logic [7:0] last_set;
      logic [7:0] first_set;
      logic [7:0] pop_count;
   } result_type;

endpackage

/* rtl/varint_bit_scan_popcount.sv */
// Top level of the varint bit scanner: population count and lowest/highest set bit.
//
// Usage: numbers arrive one byte per request on the req_ channel, least
// significant byte first. req_tuser selects the format of each byte: 0 means a
// 7-bit group whose bit 7 says more bytes follow, 1 means a plain 8-bit byte
// whose end is marked by req_tlast (req_tlast is ignored for group bytes).
// When the final byte of a number is accepted, one result goes out on the rsp_
// channel: population count, index of the lowest and of the highest set bit
// (0xFF when the number is zero) and a too_long flag for numbers with more
// than MAX_BYTES bytes. Bytes beyond MAX_BYTES are not scanned.
// Throughput is one byte per cycle while req_tready is high: each byte is
// scanned by a short combinational path into the running count registers. The
// result is valid in the cycle after its final byte is accepted, held in the
// result register.
// When the receiver stalls, the result register holds its word; a new byte is
// still taken as long as the result register is empty or being emptied in the
// same cycle, so req_tready drops only while a result waits and rsp_tready is
// low.
// Synchronous reset clears the running state and the result valid flag; no
// clearing pass is needed.
module varint_bit_scan_popcount
   import vbsp_pkg::*;
#(
   parameter int MAX_BYTES = DEFAULT_MAX_BYTES
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // Fields from bit 0: data_byte[7:0].
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,
   // Fields from bit 0: plain_bytes.
   input  logic                      req_tuser,
   input  logic                      req_tlast,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // Fields from bit 0: pop_count[7:0], first_set[15:8], last_set[23:16],
   // too_long[24], zeros above.
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata
);

   localparam int CountWidth = $clog2(MAX_BYTES + 1);
   localparam logic [CountWidth-1:0] ByteLimit = CountWidth'(MAX_BYTES);

   // Running state of the number being scanned.
   logic [7:0]            bit_offset_ff, bit_offset_in;
   logic [7:0]            ones_so_far_ff, ones_so_far_in;
   logic                  seen_one_ff, seen_one_in;
   logic [6:0]            lowest_index_ff, lowest_index_in;
   logic [6:0]            highest_index_ff, highest_index_in;
   logic [CountWidth-1:0] bytes_seen_ff, bytes_seen_in;
   logic                  overflowed_ff, overflowed_in;

   // Result register.
   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            result_ff, result_in;

   // Byte scan signals.
   logic                  req_fire;
   logic                  scan_enable;
   logic                  number_done;
   logic [7:0]            value_bits;
   logic [3:0]            byte_ones;
   logic                  byte_has_one;
   logic [2:0]            low_pos;
   logic [2:0]            high_pos;
   logic [6:0]            low_index;
   logic [6:0]            high_index;
   logic [8:0]            ones_sum;
   logic [8:0]            offset_sum;

   // A byte is taken when the result register is free or being emptied.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   // Bytes past the limit are counted as overflow and not scanned.
   assign scan_enable = bytes_seen_ff < ByteLimit;
   assign value_bits  = req_tuser ? req_tdata : (req_tdata & GROUP_VALUE_MASK);
   assign number_done = req_tuser ? req_tlast : !req_tdata[CONT_BIT];

   // Population count and lowest/highest set position of this byte.
   always_comb begin
      logic [3:0] count;
      logic       found;
      count    = '0;
      found    = 1'b0;
      low_pos  = '0;
      high_pos = '0;
      for (int k = 0; k < BYTE_BITS; k++) begin
         if (value_bits[k]) begin
            count    = count + 4'd1;
            high_pos = 3'(k);
            if (!found) begin
               low_pos = 3'(k);
            end
            found = 1'b1;
         end
      end
      byte_ones    = count;
      byte_has_one = found;
   end

   // Absolute bit indexes, saturated at the widest index.
   always_comb begin
      logic [8:0] low_sum;
      logic [8:0] high_sum;
      low_sum    = {1'b0, bit_offset_ff} + {6'd0, low_pos};
      high_sum   = {1'b0, bit_offset_ff} + {6'd0, high_pos};
      low_index  = (low_sum > {2'd0, INDEX_MAX}) ? INDEX_MAX : low_sum[6:0];
      high_index = (high_sum > {2'd0, INDEX_MAX}) ? INDEX_MAX : high_sum[6:0];
   end

   assign ones_sum   = {1'b0, ones_so_far_ff} + {5'd0, byte_ones};
   assign offset_sum = {1'b0, bit_offset_ff}
                     + (req_tuser ? 9'(BYTE_BITS) : 9'(GROUP_BITS));

   // Next running state and result word.
   always_comb begin
      logic [7:0]            offset_next;
      logic [7:0]            ones_next;
      logic                  seen_next;
      logic [6:0]            lowest_next;
      logic [6:0]            highest_next;
      logic [CountWidth-1:0] bytes_next;
      logic                  over_next;

      offset_next  = bit_offset_ff;
      ones_next    = ones_so_far_ff;
      seen_next    = seen_one_ff;
      lowest_next  = lowest_index_ff;
      highest_next = highest_index_ff;
      bytes_next   = bytes_seen_ff;
      over_next    = overflowed_ff;

      if (scan_enable) begin
         bytes_next  = bytes_seen_ff + CountWidth'(1);
         offset_next = offset_sum[8] ? OFFSET_MAX : offset_sum[7:0];
         ones_next   = ones_sum[8] ? COUNT_MAX : ones_sum[7:0];
         if (byte_has_one) begin
            if (!seen_one_ff) begin
               lowest_next = low_index;
            end
            seen_next    = 1'b1;
            highest_next = high_index;
         end
      end else begin
         over_next = 1'b1;
      end

      result_in.pop_count = ones_next;
      result_in.first_set = seen_next ? {1'b0, lowest_next} : NO_BIT_SET;
      result_in.last_set  = seen_next ? {1'b0, highest_next} : NO_BIT_SET;
      result_in.too_long  = over_next;

      bit_offset_in    = bit_offset_ff;
      ones_so_far_in   = ones_so_far_ff;
      seen_one_in      = seen_one_ff;
      lowest_index_in  = lowest_index_ff;
      highest_index_in = highest_index_ff;
      bytes_seen_in    = bytes_seen_ff;
      overflowed_in    = overflowed_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;

      if (req_fire) begin
         if (number_done) begin
            bit_offset_in    = '0;
            ones_so_far_in   = '0;
            seen_one_in      = 1'b0;
            lowest_index_in  = '0;
            highest_index_in = '0;
            bytes_seen_in    = '0;
            overflowed_in    = 1'b0;
            rsp_valid_in     = 1'b1;
         end else begin
            bit_offset_in    = offset_next;
            ones_so_far_in   = ones_next;
            seen_one_in      = seen_next;
            lowest_index_in  = lowest_next;
            highest_index_in = highest_next;
            bytes_seen_in    = bytes_next;
            overflowed_in    = over_next;
         end
      end
   end

   // Control and running state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_offset_ff    <= '0;
         ones_so_far_ff   <= '0;
         seen_one_ff      <= 1'b0;
         lowest_index_ff  <= '0;
         highest_index_ff <= '0;
         bytes_seen_ff    <= '0;
         overflowed_ff    <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         bit_offset_ff    <= bit_offset_in;
         ones_so_far_ff   <= ones_so_far_in;
         seen_one_ff      <= seen_one_in;
         lowest_index_ff  <= lowest_index_in;
         highest_index_ff <= highest_index_in;
         bytes_seen_ff    <= bytes_seen_in;
         overflowed_ff    <= overflowed_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Result payload register, loaded when a number ends.
   always_ff @(posedge clock) begin
      if (req_fire && number_done) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_WIDTH - $bits(result_type)){1'b0}}, result_ff};

   // A group byte without continuation always produces a result next cycle.
   a_group_end_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_fire && !req_tuser && !req_tdata[CONT_BIT] |=> rsp_valid_ff)
      else $error("group end byte did not produce a result");

   // The byte counter never passes the limit.
   a_bytes_bounded: assert property (@(posedge clock) disable iff (reset)
      bytes_seen_ff <= ByteLimit)
      else $error("byte counter passed the limit");

   // Overflow is only flagged once the byte limit is reached.
   a_overflow_at_limit: assert property (@(posedge clock) disable iff (reset)
      overflowed_ff |-> bytes_seen_ff == ByteLimit)
      else $error("overflow flagged below the byte limit");

   // Without a set bit the running count stays zero.
   a_no_bits_no_count: assert property (@(posedge clock) disable iff (reset)
      !seen_one_ff |-> ones_so_far_ff == '0)
      else $error("count is nonzero with no set bit seen");

   // The highest set bit is never below the lowest one.
   a_index_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.first_set != NO_BIT_SET
         |-> result_ff.last_set >= result_ff.first_set)
      else $error("highest index below lowest index");

   // A zero result reports both indexes as missing.
   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.pop_count == '0
         |-> result_ff.first_set == NO_BIT_SET && result_ff.last_set == NO_BIT_SET)
      else $error("zero number reported a set bit");

endmodule

/* bench/tb.sv */
// Self-checking bench for the varint bit scanner: byte requests in, count results checked.
module tb;
   import vbsp_pkg::*;

   localparam int MAX_BYTES     = DEFAULT_MAX_BYTES;
   localparam int RANDOM_BYTES  = 500;
   localparam int IDLE_PERCENT  = 8;
   localparam int HOLD_CYCLES   = 40;
   localparam int DRAIN_CYCLES  = 10;
   localparam int RUN_LIMIT     = 400000;

   // Number formats and the ways a random number is built.
   typedef enum int {
      NUM_GROUP,
      NUM_PLAIN,
      NUM_MIXED,
      NUM_NOISE
   } number_kind_type;

   // One byte request as it goes onto the request channel.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       plain_bytes;
      logic       last_byte;
   } byte_request_type;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata  = '0;
   logic                      req_tuser  = 1'b0;
   logic                      req_tlast  = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;

   byte_request_type pending_bytes[$];
   result_type       expected_counts[$];

   // Running state of the bit scan, kept apart from the block's own.
   int scan_offset;
   int ones_count;
   bit any_one;
   int low_idx;
   int high_idx;
   int byte_count;
   bit too_many;

   bit req_taken;
   int sent_count;
   int checked_count;
   int error_count;
   int too_long_count;
   int zero_count;
   int hold_left;
   bit hold_done;

   varint_bit_scan_popcount #(
      .MAX_BYTES (MAX_BYTES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Clear the scan state at the start of each number.
   function automatic void clear_scan();
      scan_offset = 0;
      ones_count  = 0;
      any_one     = 1'b0;
      low_idx     = 0;
      high_idx    = 0;
      byte_count  = 0;
      too_many    = 1'b0;
   endfunction

   // Scan one accepted byte and say whether it ends a number, with its counts.
   task automatic scan_byte(input logic [7:0] data_byte, input logic plain,
                            input logic last, output logic done, output result_type res);
      int         width;
      int         idx;
      logic [7:0] value;
      if (byte_count >= MAX_BYTES) begin
         // Bytes past the limit only mark the number as too long.
         too_many = 1'b1;
      end else begin
         byte_count++;
         width = plain ? BYTE_BITS : GROUP_BITS;
         value = plain ? data_byte : (data_byte & GROUP_VALUE_MASK);
         for (int k = 0; k < width; k++) begin
            if (value[k]) begin
               idx = scan_offset + k;
               if (idx > int'(INDEX_MAX))
                  idx = int'(INDEX_MAX);
               if (ones_count < int'(COUNT_MAX))
                  ones_count++;
               if (!any_one)
                  low_idx = idx;
               any_one  = 1'b1;
               high_idx = idx;
            end
         end
         scan_offset = scan_offset + width;
         if (scan_offset > int'(OFFSET_MAX))
            scan_offset = int'(OFFSET_MAX);
      end
      done          = plain ? last : !data_byte[CONT_BIT];
      res.pop_count = 8'(ones_count);
      res.first_set = any_one ? 8'(low_idx) : NO_BIT_SET;
      res.last_set  = any_one ? 8'(high_idx) : NO_BIT_SET;
      res.too_long  = too_many;
      if (done)
         clear_scan();
   endtask

   task automatic queue_byte(input logic [7:0] data_byte, input logic plain, input logic last);
      byte_request_type item;
      item.data_byte   = data_byte;
      item.plain_bytes = plain;
      item.last_byte   = last;
      pending_bytes.push_back(item);
   endtask

   // Sender: offer the next request at the falling edge, holding it until taken.
   always @(negedge clock) begin
      byte_request_type item;
      if (!reset && (!req_tvalid || req_taken)) begin
         if (pending_bytes.size() != 0 &&
             ((sent_count >= 250 && sent_count < 350) ||
              $urandom_range(0, 99) >= IDLE_PERCENT)) begin
            item = pending_bytes.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= item.data_byte;
            req_tuser  <= item.plain_bytes;
            req_tlast  <= item.last_byte;
            sent_count++;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, a quiet stretch, and one long hold-off.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!hold_done && checked_count >= 60) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else if (checked_count >= 80 && checked_count < 120) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // Monitor: predict on each accepted request, check each accepted result.
   always @(posedge clock) begin
      logic       done;
      result_type res;
      result_type want;
      result_type got;
      req_taken = !reset && req_tvalid && req_tready;
      if (req_taken) begin
         scan_byte(req_tdata, req_tuser, req_tlast, done, res);
         if (done) begin
            expected_counts.push_back(res);
            if (res.too_long)
               too_long_count++;
            if (res.first_set == NO_BIT_SET)
               zero_count++;
         end
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = result_type'(rsp_tdata[$bits(result_type)-1:0]);
         if (expected_counts.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result %h", $time, rsp_tdata);
         end else begin
            want = expected_counts.pop_front();
            checked_count++;
            if (got.pop_count !== want.pop_count) begin
               error_count++;
               $display("%0t: pop_count expected %0d, got %0d",
                        $time, want.pop_count, got.pop_count);
            end
            if (got.first_set !== want.first_set) begin
               error_count++;
               $display("%0t: first_set expected %h, got %h",
                        $time, want.first_set, got.first_set);
            end
            if (got.last_set !== want.last_set) begin
               error_count++;
               $display("%0t: last_set expected %h, got %h",
                        $time, want.last_set, got.last_set);
            end
            if (got.too_long !== want.too_long) begin
               error_count++;
               $display("%0t: too_long expected %b, got %b",
                        $time, want.too_long, got.too_long);
            end
            if (rsp_tdata[RSP_DATA_WIDTH-1:$bits(result_type)] !== '0) begin
               error_count++;
               $display("%0t: pad bits expected 0, got %h", $time,
                        rsp_tdata[RSP_DATA_WIDTH-1:$bits(result_type)]);
            end
         end
      end
   end

   // Stimulus, reset and the end of the run.
   initial begin : stimulus
      number_kind_type kind;
      int              len;
      int              fill;
      int              pick;
      logic [7:0]      value;
      logic            plain;
      logic            final_byte;
      clear_scan();

      // Directed numbers: zero, all ones, plain end marks and format changes.
      queue_byte(8'h00, 1'b0, 1'b0);
      queue_byte(8'h7F, 1'b0, 1'b1);
      queue_byte(8'h80, 1'b1, 1'b1);
      queue_byte(8'h81, 1'b0, 1'b1);
      queue_byte(8'h01, 1'b1, 1'b1);
      queue_byte(8'h00, 1'b1, 1'b0);
      queue_byte(8'h40, 1'b0, 1'b0);
      // Too many bytes: seventeen full plain bytes, the last one not scanned.
      for (int i = 0; i < MAX_BYTES + 1; i++)
         queue_byte(8'hFF, 1'b1, i == MAX_BYTES);

      // Random numbers, mostly well formed, some with too many bytes.
      while (pending_bytes.size() < 24 + RANDOM_BYTES) begin
         pick = $urandom_range(0, 99);
         kind = pick < 42 ? NUM_GROUP : pick < 78 ? NUM_PLAIN :
                pick < 92 ? NUM_MIXED : NUM_NOISE;
         len  = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_BYTES - 2, MAX_BYTES + 4)
                                            : $urandom_range(1, 6);
         fill = $urandom_range(0, 3);
         for (int i = 0; i < len; i++) begin
            final_byte = (i == len - 1);
            value = fill == 0 ? 8'h00 : fill == 1 ? 8'hFF : 8'($urandom);
            case (kind)
               NUM_GROUP: plain = 1'b0;
               NUM_PLAIN: plain = 1'b1;
               default:   plain = 1'($urandom_range(0, 1));
            endcase
            if (kind == NUM_NOISE) begin
               queue_byte(value, plain, 1'($urandom_range(0, 1)));
            end else if (plain) begin
               queue_byte(value, 1'b1, final_byte);
            end else begin
               value[CONT_BIT] = !final_byte;
               queue_byte(value, 1'b0, 1'($urandom_range(0, 1)));
            end
         end
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() != 0 || req_tvalid || expected_counts.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d byte requests and checked %0d results,", sent_count, checked_count);
      $display("including %0d zero numbers and %0d over-long numbers.",
               zero_count, too_long_count);
      if (error_count == 0 && expected_counts.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Watchdog for a stuck handshake.
   initial begin
      #RUN_LIMIT;
      $display("Timeout with %0d results still expected.", expected_counts.size());
      $display("FAILED: results differ");
      $finish;
   end

endmodule

/* varint_bit_scan_popcount.f */
rtl/vbsp_pkg.sv
rtl/varint_bit_scan_popcount.sv
bench/tb.sv
